FILE: rtl/gsfp_pkg.sv
// Shared types, byte codes and helper functions for the gyro serial frame parser.
// No dependencies; imported by every other RTL file of the block.
`default_nettype none

package gsfp_pkg;

    // Default depth of the frame store
    localparam int MAX_FRAME_BYTES_DEF = 9;

    // Frame byte codes
    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] TYPE_ANGLE = 8'h81;
    localparam logic [7:0] TYPE_RATE  = 8'h82;
    localparam logic [7:0] TYPE_BOTH  = 8'h83;
    localparam logic [7:0] TYPE_LAST  = 8'h84;
    localparam logic [7:0] END_BYTE   = 8'h0d;

    // Frame lengths, header to terminator
    localparam int          LEN_W     = 4;
    localparam logic [LEN_W-1:0] LEN_SHORT = 4'd7;
    localparam logic [LEN_W-1:0] LEN_LONG  = 4'd9;

    // Fixed positions within a stored frame
    localparam int POS_TYPE       = 1;
    localparam int POS_AUX        = 2;
    localparam int POS_SUM_SHORT  = 5;
    localparam int POS_END_SHORT  = 6;
    localparam int POS_SUM_LONG   = 7;
    localparam int POS_END_LONG   = 8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One received byte with its classification
    typedef struct packed {
        logic [7:0] data;
        logic       is_start;
        logic       is_type;
    } rx_item_t;

    // Parser states
    typedef enum logic [4:0] {
        ST_HUNT      = 5'b00001,
        ST_WAIT_TYPE = 5'b00010,
        ST_COLLECT   = 5'b00100,
        ST_JUDGE     = 5'b01000,
        ST_RESCAN    = 5'b10000
    } parse_state_t;

    function automatic logic is_type_byte(input logic [7:0] b);
        return (b >= TYPE_ANGLE) && (b <= TYPE_LAST);
    endfunction

    function automatic logic [LEN_W-1:0] frame_len(input logic [7:0] type_b);
        return (type_b == TYPE_BOTH) ? LEN_LONG : LEN_SHORT;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gsfp_front.sv
// Front end: classifies each received byte and holds it in a short queue.
// Depends on gsfp_pkg.
`default_nettype none

module gsfp_front
    import gsfp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire logic [7:0] rx_byte,
    output logic          item_valid,
    input  wire logic     item_stall,
    output rx_item_t      item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    rx_item_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               push, pop;
    rx_item_t           new_item;

    // Classify the incoming byte
    always_comb
    begin
        new_item.data     = rx_byte;
        new_item.is_start = (rx_byte == START_BYTE);
        new_item.is_type  = is_type_byte(rx_byte);
    end

    assign in_stall   = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign item_valid = (fill_reg != '0);
    assign pop        = item_valid && !item_stall;
    assign item       = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gsfp_back.sv
// Back end: frame parser state machine, frame store, rescan and result register.
// Depends on gsfp_pkg.
`default_nettype none

module gsfp_back
    import gsfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire rx_item_t    item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       frame_kind,
    output logic [7:0]       aux_byte,
    output logic [15:0]      angle_raw,
    output logic signed [15:0] rate_raw,
    output logic             checksum_ok
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int IDX_W = $clog2(MAX_FRAME_BYTES);

    parse_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        store_reg  [MAX_FRAME_BYTES];
    logic [7:0]        store_next [MAX_FRAME_BYTES];

    logic              out_valid_reg;
    logic [1:0]        kind_reg;
    logic [7:0]        aux_reg;
    logic [15:0]       angle_reg;
    logic signed [15:0] rate_reg;
    logic              sum_ok_reg;

    logic              taking;
    logic              emit;
    logic              slot_free;
    logic              is_both;
    logic [CNT_W-1:0]  len_cur;
    logic [CNT_W-1:0]  len_cand;
    logic [7:0]        term_b;
    logic [7:0]        chk_b;
    logic [7:0]        sum_b;
    logic [1:0]        kind_w;
    logic [15:0]       angle_w;
    logic [15:0]       rate_w;

    // Bytes are taken only in the collecting states
    assign taking     = (state_reg == ST_HUNT) || (state_reg == ST_WAIT_TYPE)
                        || (state_reg == ST_COLLECT);
    assign item_stall = !taking;
    assign slot_free  = !out_valid_reg || !out_stall;

    // Frame decode from fixed store positions
    always_comb
    begin
        is_both  = (store_reg[POS_TYPE] == TYPE_BOTH);
        len_cur  = CNT_W'(frame_len(store_reg[POS_TYPE]));
        len_cand = CNT_W'(frame_len(store_reg[1]));
        term_b   = is_both ? store_reg[POS_END_LONG] : store_reg[POS_END_SHORT];
        chk_b    = is_both ? store_reg[POS_SUM_LONG] : store_reg[POS_SUM_SHORT];
        sum_b    = store_reg[1] + store_reg[2] + store_reg[3] + store_reg[4]
                   + (is_both ? (store_reg[5] + store_reg[6]) : 8'd0);
        kind_w   = store_reg[POS_TYPE][1:0] - 2'd1;
        angle_w  = '0;
        rate_w   = '0;
        if ((store_reg[POS_TYPE] == TYPE_ANGLE) || is_both)
        begin
            angle_w = {store_reg[3], store_reg[4]};
        end
        if (store_reg[POS_TYPE] == TYPE_RATE)
        begin
            rate_w = {store_reg[3], store_reg[4]};
        end
        else if (is_both)
        begin
            rate_w = {store_reg[5], store_reg[6]};
        end
    end

    // Parser next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        store_next = store_reg;
        emit       = 1'b0;
        case (state_reg)
            ST_HUNT:
            begin
                if (item_valid)
                begin
                    count_next = '0;
                    if (item.is_start)
                    begin
                        store_next[0] = item.data;
                        count_next    = CNT_W'(1);
                        state_next    = ST_WAIT_TYPE;
                    end
                end
            end
            ST_WAIT_TYPE:
            begin
                if (item_valid)
                begin
                    if (item.is_type)
                    begin
                        store_next[POS_TYPE] = item.data;
                        count_next           = CNT_W'(2);
                        state_next           = ST_COLLECT;
                    end
                    else if (item.is_start)
                    begin
                        store_next[0] = item.data;
                        count_next    = CNT_W'(1);
                    end
                    else
                    begin
                        count_next = '0;
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_COLLECT:
            begin
                if (item_valid)
                begin
                    if ((count_reg >= len_cur) || (count_reg >= CNT_W'(MAX_FRAME_BYTES)))
                    begin
                        count_next = '0;
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        store_next[count_reg[IDX_W-1:0]] = item.data;
                        count_next = count_reg + 1'b1;
                        if (count_reg + 1'b1 == len_cur)
                        begin
                            state_next = ST_JUDGE;
                        end
                    end
                end
            end
            ST_JUDGE:
            begin
                if (term_b == END_BYTE)
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        count_next = '0;
                        state_next = ST_HUNT;
                    end
                end
                else
                begin
                    // Drop start and type bytes, scan from the third byte on
                    for (int i = 0; i < MAX_FRAME_BYTES - 2; i++)
                    begin
                        store_next[i] = store_reg[i + 2];
                    end
                    count_next = count_reg - CNT_W'(2);
                    state_next = ST_RESCAN;
                end
            end
            ST_RESCAN:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_HUNT;
                end
                else if ((store_reg[0] == START_BYTE) && (count_reg == CNT_W'(1)))
                begin
                    // Lone start byte at the tail: wait for its type byte
                    state_next = ST_WAIT_TYPE;
                end
                else if ((store_reg[0] == START_BYTE) && is_type_byte(store_reg[1]))
                begin
                    if (count_reg < len_cand)
                    begin
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        count_next = len_cand;
                        state_next = ST_JUDGE;
                    end
                end
                else
                begin
                    // No header here: slide one byte on
                    for (int i = 0; i < MAX_FRAME_BYTES - 1; i++)
                    begin
                        store_next[i] = store_reg[i + 1];
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                count_next = '0;
                state_next = ST_HUNT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Frame store and result payload
    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
        if (emit)
        begin
            kind_reg   <= kind_w;
            aux_reg    <= store_reg[POS_AUX];
            angle_reg  <= angle_w;
            rate_reg   <= $signed(rate_w);
            sum_ok_reg <= (sum_b == chk_b);
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_kind  = kind_reg;
    assign aux_byte    = aux_reg;
    assign angle_raw   = angle_reg;
    assign rate_raw    = rate_reg;
    assign checksum_ok = sum_ok_reg;

endmodule

`default_nettype wire

FILE: rtl/gyro_serial_frame_parser.sv
// Top level of the gyro serial frame parser: front queue and back parser.
// Depends on gsfp_pkg, gsfp_front and gsfp_back.
//
// Takes one received UART byte per item and emits one result per frame that
// ends in 0x0d: frame kind, aux byte, raw angle, raw signed rate and checksum
// flag (a result is given whether the checksum matches or not). A two-item
// queue takes bytes at up to one per cycle while it is not full. The parser
// behind it collects the bytes of a frame and then judges the complete frame.
// On a bad terminator it rescans: it drops the start and type bytes, slides
// past the stored bytes one at a time, then finds a header or gives up, and
// judges a second time where the tail already holds a whole frame. The worst
// case of parser time for a terminator byte is set by the one-byte-per-cycle
// rescan over the nine-byte frame store. A waiting result sits in an output
// register and holds off only a judge.
`default_nettype none

module gyro_serial_frame_parser
    import gsfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    rx_byte,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         frame_kind,
    output logic [7:0]         aux_byte,
    output logic [15:0]        angle_raw,
    output logic signed [15:0] rate_raw,
    output logic               checksum_ok
);

    logic     item_valid;
    logic     item_stall;
    rx_item_t item;

    // Byte classification and queue
    gsfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item)
    );

    // Frame parser and result register
    gsfp_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_kind  (frame_kind),
        .aux_byte    (aux_byte),
        .angle_raw   (angle_raw),
        .rate_raw    (rate_raw),
        .checksum_ok (checksum_ok)
    );

endmodule

`default_nettype wire

FILE: tb/gyro_serial_frame_parser_test.sv
// Self-checking testbench for gyro_serial_frame_parser: byte stream in, decoded frames out.
// Depends on gsfp_pkg and the RTL of the block; a local frame decoder predicts every reading.
`default_nettype none

module gyro_serial_frame_parser_test;
    import gsfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Decoder phases: hunting for the start byte, waiting for a type byte, collecting
    typedef enum logic [1:0] {
        PH_HUNT      = 2'd0,
        PH_WAIT_TYPE = 2'd1,
        PH_COLLECT   = 2'd2
    } hunt_phase_t;

    // One decoded frame as it leaves the block
    typedef struct {
        logic [1:0]         kind;
        logic [7:0]         aux;
        logic [15:0]        angle;
        logic signed [15:0] rate;
        logic               sum_ok;
    } gyro_reading_t;

    localparam int STORE_DEPTH = 9;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         frame_kind;
    logic [7:0]         aux_byte;
    logic [15:0]        angle_raw;
    logic signed [15:0] rate_raw;
    logic               checksum_ok;

    // Decoder state
    hunt_phase_t  dec_phase = PH_HUNT;
    logic [7:0]   dec_store [STORE_DEPTH];
    int           dec_count = 0;

    gyro_reading_t awaited_readings[$];
    gyro_reading_t seen_reading;
    gyro_reading_t oldest_reading;
    logic [7:0]    byte_script[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    int readings_seen = 0;
    int mismatch_count = 0;

    gyro_serial_frame_parser uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_kind  (frame_kind),
        .aux_byte    (aux_byte),
        .angle_raw   (angle_raw),
        .rate_raw    (rate_raw),
        .checksum_ok (checksum_ok)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard limit on the run
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit is_frame_type(input logic [7:0] b);
        return (b >= TYPE_ANGLE) && (b <= TYPE_LAST);
    endfunction

    function automatic int bytes_in_frame(input logic [7:0] ftype);
        return (ftype == TYPE_BOTH) ? 9 : 7;
    endfunction

    // Decode the stored frame of length need into an awaited reading
    task automatic queue_reading(input int need);
        gyro_reading_t r;
        logic [7:0]    sum;
        logic [7:0]    ftype;
        int            i;
        ftype = dec_store[POS_TYPE];
        sum = 8'h00;
        for (i = 1; i + 2 < need; i++)
            sum += dec_store[i];
        r.kind   = 2'(ftype - TYPE_ANGLE);
        r.aux    = dec_store[POS_AUX];
        r.angle  = 16'h0000;
        r.rate   = 16'sh0000;
        if (ftype == TYPE_ANGLE || ftype == TYPE_BOTH)
            r.angle = {dec_store[3], dec_store[4]};
        if (ftype == TYPE_RATE)
            r.rate = {dec_store[3], dec_store[4]};
        else if (ftype == TYPE_BOTH)
            r.rate = {dec_store[5], dec_store[6]};
        r.sum_ok = (sum == dec_store[need - 2]);
        awaited_readings = {awaited_readings, r};
    endtask

    // Full frame held: emit on a good terminator, else rescan for the next header
    task automatic judge_stored_frame();
        int need;
        int p;
        int i;
        bit found;
        bit done;
        done = 1'b0;
        while (!done)
        begin
            need = bytes_in_frame(dec_store[POS_TYPE]);
            if (dec_store[need - 1] == END_BYTE)
            begin
                queue_reading(need);
                dec_phase = PH_HUNT;
                dec_count = 0;
                done = 1'b1;
            end
            else
            begin
                found = 1'b0;
                for (p = 2; p < dec_count && !found && !done; p++)
                begin
                    if (dec_store[p] == START_BYTE)
                    begin
                        if (p + 1 == dec_count)
                        begin
                            // start byte is the last one held: wait for a type byte
                            dec_store[0] = START_BYTE;
                            dec_count = 1;
                            dec_phase = PH_WAIT_TYPE;
                            done = 1'b1;
                        end
                        else if (is_frame_type(dec_store[p + 1]))
                        begin
                            for (i = 0; i < dec_count - p; i++)
                                dec_store[i] = dec_store[i + p];
                            dec_count = dec_count - p;
                            dec_phase = PH_COLLECT;
                            found = 1'b1;
                        end
                    end
                end
                if (!done)
                begin
                    if (!found)
                    begin
                        dec_phase = PH_HUNT;
                        dec_count = 0;
                        done = 1'b1;
                    end
                    else if (dec_count < bytes_in_frame(dec_store[POS_TYPE]))
                        done = 1'b1;
                    else
                        dec_count = bytes_in_frame(dec_store[POS_TYPE]);
                end
            end
        end
    endtask

    // Advance the decoder by one accepted byte
    task automatic track_byte(input logic [7:0] b);
        int need;
        case (dec_phase)
            PH_WAIT_TYPE:
            begin
                if (is_frame_type(b))
                begin
                    dec_store[POS_TYPE] = b;
                    dec_count = 2;
                    dec_phase = PH_COLLECT;
                end
                else if (b == START_BYTE)
                begin
                    dec_store[0] = b;
                    dec_count = 1;
                end
                else
                begin
                    dec_phase = PH_HUNT;
                    dec_count = 0;
                end
            end
            PH_COLLECT:
            begin
                need = bytes_in_frame(dec_store[POS_TYPE]);
                if (dec_count >= need || dec_count >= STORE_DEPTH)
                begin
                    dec_phase = PH_HUNT;
                    dec_count = 0;
                end
                else
                begin
                    dec_store[dec_count] = b;
                    dec_count++;
                    if (dec_count == need)
                        judge_stored_frame();
                end
            end
            default:
            begin
                dec_phase = PH_HUNT;
                dec_count = 0;
                if (b == START_BYTE)
                begin
                    dec_store[0] = b;
                    dec_count = 1;
                    dec_phase = PH_WAIT_TYPE;
                end
            end
        endcase
    endtask

    // Offer one item, optionally after idle cycles; returns on the accepting edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        track_byte(b);
        bytes_sent++;
    endtask

    // Drop valid after the last accepted item and wait on a clock edge
    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic play_script();
        int k;
        for (k = 0; k < byte_script.size(); k++)
            send_byte(byte_script[k]);
        byte_script.delete();
    endtask

    // Header, type, aux, data (2 or 4 bytes), checksum, terminator
    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] aux,
                              input logic [31:0] data, input bit sum_good,
                              input logic [7:0] term);
        logic [7:0] sum;
        int         k;
        byte_script.delete();
        byte_script = {byte_script, ftype};
        byte_script = {byte_script, aux};
        if (ftype == TYPE_BOTH)
        begin
            byte_script = {byte_script, data[31:24]};
            byte_script = {byte_script, data[23:16]};
        end
        byte_script = {byte_script, data[15:8]};
        byte_script = {byte_script, data[7:0]};
        sum = 8'h00;
        for (k = 0; k < byte_script.size(); k++)
            sum += byte_script[k];
        if (!sum_good)
            sum = sum ^ (8'h01 << $urandom_range(7));
        byte_script.push_front(START_BYTE);
        byte_script = {byte_script, sum};
        byte_script = {byte_script, term};
        play_script();
    endtask

    // Byte biased towards header codes so rescans find candidates
    function automatic logic [7:0] header_biased_byte();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return START_BYTE;
        else if (r < 30)
            return 8'(TYPE_ANGLE + $urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    // Receiver: random stalls, or a long counted hold-off when requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result checker, sampled mid-cycle so the accepting edge is known
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_reading.kind   = frame_kind;
            seen_reading.aux    = aux_byte;
            seen_reading.angle  = angle_raw;
            seen_reading.rate   = rate_raw;
            seen_reading.sum_ok = checksum_ok;
            readings_seen++;
            if (awaited_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reading: kind %0d aux %h angle %h rate %0d ok %b",
                             frame_kind, aux_byte, angle_raw, rate_raw, checksum_ok);
            end
            else
            begin
                oldest_reading = awaited_readings.pop_front();
                if (seen_reading.kind != oldest_reading.kind ||
                    seen_reading.aux != oldest_reading.aux ||
                    seen_reading.angle != oldest_reading.angle ||
                    seen_reading.rate != oldest_reading.rate ||
                    seen_reading.sum_ok != oldest_reading.sum_ok)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"reading %0d: want kind %0d aux %h angle %h rate %0d",
                                  " ok %b, got kind %0d aux %h angle %h rate %0d ok %b"},
                                 readings_seen,
                                 oldest_reading.kind, oldest_reading.aux,
                                 oldest_reading.angle, oldest_reading.rate,
                                 oldest_reading.sum_ok,
                                 seen_reading.kind, seen_reading.aux,
                                 seen_reading.angle, seen_reading.rate,
                                 seen_reading.sum_ok);
                end
            end
        end
    end

    // Every frame kind, field extremes, good and bad checksum
    task automatic test_frame_kinds();
        send_frame(TYPE_ANGLE, 8'h00, 32'h0000_0000, 1'b1, END_BYTE);
        send_frame(TYPE_RATE,  8'hff, 32'h0000_8000, 1'b0, END_BYTE);
        send_frame(TYPE_BOTH,  8'h5a, 32'hffff_7fff, 1'b1, END_BYTE);
        send_frame(TYPE_LAST,  8'ha5, 32'h0000_ffff, 1'b1, END_BYTE);
    endtask

    // Repeated start byte, and type bytes just outside the range
    task automatic test_header_hunt();
        byte_script = {START_BYTE, START_BYTE, 8'h80, START_BYTE, 8'h85, 8'hff};
        play_script();
        byte_script = {START_BYTE, START_BYTE};
        play_script();
        // the second start byte begins this frame
        byte_script = {TYPE_ANGLE, 8'h01, 8'h12, 8'h34, 8'hc8, END_BYTE};
        play_script();
    endtask

    // Bad terminators and the paths the rescan can take
    task automatic test_rescan();
        // no header among the stored bytes
        byte_script = {START_BYTE, TYPE_LAST, 8'h00, 8'h00, 8'h00, 8'h84, 8'hee};
        play_script();
        // candidate with a bad type byte, then a good header with a short tail
        byte_script = {START_BYTE, TYPE_BOTH, 8'haa, START_BYTE, 8'h55, START_BYTE,
                       TYPE_RATE, 8'h10, 8'h44, 8'h20, 8'hf6, END_BYTE};
        play_script();
        // start byte as the last one held
        byte_script = {START_BYTE, TYPE_ANGLE, 8'h11, 8'h22, 8'h33, 8'h00, START_BYTE,
                       TYPE_LAST, 8'ha5, 8'h00, 8'h00, 8'h29, END_BYTE};
        play_script();
        // header whose tail is already a whole frame, judged at once and rescanned
        byte_script = {START_BYTE, TYPE_BOTH, START_BYTE, TYPE_ANGLE, 8'h7f, 8'h00,
                       8'h01, 8'h01, START_BYTE,
                       TYPE_RATE, 8'h00, 8'hff, 8'hff, 8'h80, END_BYTE};
        play_script();
    endtask

    // Mostly well-formed frames with random content, plus broken frames and noise
    task automatic test_random_traffic(input int n_bytes, input int s_idle, input int r_idle);
        int         stop_at;
        int         r;
        int         k;
        logic [7:0] ftype;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            r = $urandom_range(99);
            ftype = 8'(TYPE_ANGLE + $urandom_range(3));
            if (r < 10)
            begin
                // line noise
                k = $urandom_range(1, 4);
                repeat (k) send_byte(header_biased_byte());
            end
            else if (r < 15)
            begin
                // header cut short
                send_byte(START_BYTE);
                send_byte(ftype);
                k = $urandom_range(0, 4);
                repeat (k) send_byte(8'($urandom_range(255)));
            end
            else if (r < 30)
            begin
                send_frame(ftype, header_biased_byte(),
                           {header_biased_byte(), header_biased_byte(),
                            header_biased_byte(), header_biased_byte()},
                           $urandom_range(1), header_biased_byte());
            end
            else
            begin
                send_frame(ftype, 8'($urandom_range(255)), $urandom(),
                           ($urandom_range(99) < 80), END_BYTE);
            end
        end
        stop_sending();
    endtask

    // Receiver holds off for a long stretch while frames keep arriving
    task automatic test_output_hold();
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 400;
        for (k = 0; k < 6; k++)
            send_frame(8'(TYPE_ANGLE + (k % 4)), 8'($urandom_range(255)), $urandom(),
                       1'b1, END_BYTE);
        stop_sending();
    endtask

    initial
    begin
        int w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frame_kinds();
        test_header_hunt();
        test_rescan();
        test_random_traffic(150, 30, 85);
        test_random_traffic(150, 85, 30);
        test_output_hold();
        test_random_traffic(120, 0, 0);

        // drain, then allow for a trailing rescan
        for (w = 0; w < 50000 && awaited_readings.size() != 0; w++)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (awaited_readings.size() != 0)
        begin
            mismatch_count += awaited_readings.size();
            $display("%0d readings never arrived", awaited_readings.size());
        end

        $display("Sent %0d bytes and checked %0d decoded frames, %0d mismatches.",
                 bytes_sent, readings_seen, mismatch_count);
        $display("Covered all frame kinds, header hunting, rescans, stalls on both sides.");
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/gsfp_pkg.sv
rtl/gsfp_front.sv
rtl/gsfp_back.sv
rtl/gyro_serial_frame_parser.sv
tb/gyro_serial_frame_parser_test.sv
